// ----- src/dsc_pkg.sv -----
package dsc_pkg;

  localparam int MAX_LEN_DEF   = 1024;
  localparam int ALPHABET_DEF  = 96;
  localparam int SENTINEL_CODE = 31;
  localparam int TOP_CODE      = 126;
  localparam int COUNT_W       = 19;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_SENT,
    ST_CLR,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD,
    ST_PFX_A,
    ST_PFX_B,
    ST_CL_A,
    ST_CL_B,
    ST_CL_C,
    ST_SH_A,
    ST_SH_B,
    ST_NC_A,
    ST_NC_S,
    ST_NC_W,
    ST_NC_B,
    ST_NC_C,
    ST_NC_D,
    ST_NC_E,
    ST_NC_F,
    ST_CP_A,
    ST_CP_B,
    ST_RK_A,
    ST_RK_B,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_KS_D,
    ST_KS_E,
    ST_KS_F,
    ST_RES_A,
    ST_RES_B
  } state_e;

endpackage

// ----- src/distinct_substring_counter.sv -----
// Distinct substring counter.
// Input channel: one word per character (symbol_i, has_symbol_i, last_i),
// taken when in_valid_i is high and in_stall_o is low. Characters are kept
// as ranks (code - 31); codes outside the printable range, or at or above
// ALPHABET in rank, set bad_symbol and are dropped. Past MAX_LEN-1 kept
// characters further ones are dropped and set too_long. A word with
// has_symbol_i low and last_i low is ignored.
// A word with last_i high appends the sentinel and starts the count; the
// input stalls until the result is loaded into the output register.
// Output channel: one word per string (distinct_count_o, bad_symbol_o,
// too_long_o), held while out_stall_i is high; a new string may be loaded
// while the previous result still waits.
// Processing time is set by the single read port of each memory: every
// sort pass walks its store one entry at a time, each access a read
// followed by a write-back.
// Reset clears the length, flags and sequencer; the stores need no clear as
// every entry is written before it is read.
module distinct_substring_counter
  import dsc_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         symbol_i,
  input  logic               has_symbol_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] distinct_count_o,
  output logic               bad_symbol_o,
  output logic               too_long_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int NW = $clog2(MAX_LEN + 1);
  localparam int RW = $clog2(ALPHABET);
  localparam int NB = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
  localparam int BW = $clog2(NB);
  localparam int CW = $clog2(NB + 1);
  localparam int HW = NW + 1;
  localparam int TW = 2 * NW;

  // Add two values below n and wrap once.
  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a,
                                            input logic [NW-1:0] b,
                                            input logic [NW-1:0] n);
    logic [NW:0] s;
    s = (NW+1)'(a) + (NW+1)'(b);
    if (s >= (NW+1)'(n)) begin
      s = s - (NW+1)'(n);
    end
    return s[AW-1:0];
  endfunction

  // memory ports
  logic          txt_we, sa_we, sh_we, cls_we, ncls_we, bkt_we;
  logic [AW-1:0] txt_wa, sa_wa, sh_wa, cls_wa, ncls_wa;
  logic [AW-1:0] txt_ra, sa_ra, sh_ra, cls_ra, ncls_ra;
  logic [BW-1:0] bkt_wa, bkt_ra;
  logic [RW-1:0] txt_wd, txt_rd;
  logic [AW-1:0] sa_wd, sh_wd, cls_wd, ncls_wd;
  logic [AW-1:0] sa_rd, sh_rd, cls_rd, ncls_rd;
  logic [NW-1:0] bkt_wd, bkt_rd;

  dsc_ram #(.W(RW), .D(MAX_LEN)) u_txt (.clk_i, .we_i(txt_we), .waddr_i(txt_wa),
    .wdata_i(txt_wd), .raddr_i(txt_ra), .rdata_o(txt_rd));
  dsc_ram #(.W(AW), .D(MAX_LEN)) u_sa (.clk_i, .we_i(sa_we), .waddr_i(sa_wa),
    .wdata_i(sa_wd), .raddr_i(sa_ra), .rdata_o(sa_rd));
  dsc_ram #(.W(AW), .D(MAX_LEN)) u_sh (.clk_i, .we_i(sh_we), .waddr_i(sh_wa),
    .wdata_i(sh_wd), .raddr_i(sh_ra), .rdata_o(sh_rd));
  dsc_ram #(.W(AW), .D(MAX_LEN)) u_cls (.clk_i, .we_i(cls_we), .waddr_i(cls_wa),
    .wdata_i(cls_wd), .raddr_i(cls_ra), .rdata_o(cls_rd));
  dsc_ram #(.W(AW), .D(MAX_LEN)) u_ncls (.clk_i, .we_i(ncls_we), .waddr_i(ncls_wa),
    .wdata_i(ncls_wd), .raddr_i(ncls_ra), .rdata_o(ncls_rd));
  dsc_ram #(.W(NW), .D(NB)) u_bkt (.clk_i, .we_i(bkt_we), .waddr_i(bkt_wa),
    .wdata_i(bkt_wd), .raddr_i(bkt_ra), .rdata_o(bkt_rd));

  state_e             state_q, state_d;
  logic [CW-1:0]      i_q, i_d;
  logic [NW-1:0]      n_q, n_d, len_q, len_d;
  logic               bad_q, bad_d, long_q, long_d;
  logic               first_q, first_d, place_q, place_d;
  logic [HW-1:0]      half_q, half_d;
  logic [AW-1:0]      c_q, c_d, p_q, p_d, a_q, a_d, b_q, b_d, x_q, x_d, k_q, k_d;
  logic [BW-1:0]      key_q, key_d;
  logic [NW-1:0]      run_q, run_d, h_q, h_d;
  logic [RW-1:0]      prev_q, prev_d, tx_q, tx_d;
  logic               d_q, d_d;
  logic [TW-1:0]      total_q, total_d, prod_q, prod_d;
  logic               ov_q, ov_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               obad_q, obad_d, olong_q, olong_d;

  logic          in_acc;
  logic [CW-1:0] i_nx, lim;
  logic          i_end;
  logic [7:0]    rank8;
  logic          sym_bad;
  logic [AW-1:0] cnew;
  logic [HW-1:0] half2;
  logic [NW:0]   ih, kh;
  logic [BW-1:0] key_c;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign in_acc           = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o      = ov_q;
  assign distinct_count_o = cnt_q;
  assign bad_symbol_o     = obad_q;
  assign too_long_o       = olong_q;

  assign i_nx    = i_q + CW'(1);
  assign rank8   = symbol_i - 8'(SENTINEL_CODE);
  assign sym_bad = (symbol_i <= 8'(SENTINEL_CODE)) || (symbol_i > 8'(TOP_CODE)) ||
                   ({1'b0, rank8} >= 9'(ALPHABET));
  assign half2   = half_q << 1;
  assign ih      = (NW+1)'(i_q[AW-1:0]) + (NW+1)'(h_q);
  assign kh      = (NW+1)'(k_q) + (NW+1)'(h_q);
  assign key_c   = first_q ? BW'(txt_rd) : BW'(cls_rd);

  always_comb begin
    lim = CW'(n_q);
    if (state_q == ST_CLR || state_q == ST_PFX_A || state_q == ST_PFX_B) begin
      lim = first_q ? CW'(ALPHABET) : CW'(n_q);
    end
  end

  assign i_end = (i_nx == lim);
  assign cnew  = ((i_q != '0) && (txt_rd != prev_q)) ? c_q + AW'(1) : c_q;

  always_comb begin
    state_d = state_q;
    i_d = i_q;       n_d = n_q;         len_d = len_q;
    bad_d = bad_q;   long_d = long_q;   first_d = first_q;  place_d = place_q;
    half_d = half_q; c_d = c_q;         p_d = p_q;          a_d = a_q;
    b_d = b_q;       x_d = x_q;         k_d = k_q;          key_d = key_q;
    run_d = run_q;   h_d = h_q;         prev_d = prev_q;    tx_d = tx_q;
    d_d = d_q;       total_d = total_q; prod_d = prod_q;
    ov_d = ov_q;     cnt_d = cnt_q;     obad_d = obad_q;    olong_d = olong_q;

    txt_we = 1'b0;  txt_wa = '0;  txt_wd = '0;  txt_ra = '0;
    sa_we = 1'b0;   sa_wa = '0;   sa_wd = '0;   sa_ra = '0;
    sh_we = 1'b0;   sh_wa = '0;   sh_wd = '0;   sh_ra = '0;
    cls_we = 1'b0;  cls_wa = '0;  cls_wd = '0;  cls_ra = '0;
    ncls_we = 1'b0; ncls_wa = '0; ncls_wd = '0; ncls_ra = '0;
    bkt_we = 1'b0;  bkt_wa = '0;  bkt_wd = '0;  bkt_ra = '0;

    // drop the result once taken
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_symbol_i) begin
            if (sym_bad) begin
              bad_d = 1'b1;
            end else if (len_q >= NW'(MAX_LEN - 1)) begin
              long_d = 1'b1;
            end else begin
              txt_we = 1'b1;
              txt_wa = len_q[AW-1:0];
              txt_wd = rank8[RW-1:0];
              len_d  = len_q + NW'(1);
            end
          end
          if (last_i) begin
            state_d = ST_SENT;
          end
        end
      end
      ST_SENT: begin
        txt_we  = 1'b1;
        txt_wa  = len_q[AW-1:0];
        txt_wd  = '0;
        n_d     = len_q + NW'(1);
        first_d = 1'b1;
        place_d = 1'b0;
        i_d     = '0;
        state_d = ST_CLR;
      end
      ST_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[BW-1:0];
        bkt_wd = '0;
        i_d    = i_end ? '0 : i_nx;
        if (i_end) begin
          state_d = ST_KA;
        end
      end
      ST_KA: begin
        txt_ra  = i_q[AW-1:0];
        sh_ra   = i_q[AW-1:0];
        state_d = first_q ? ST_KC : ST_KB;
      end
      ST_KB: begin
        cls_ra  = sh_rd;
        p_d     = sh_rd;
        state_d = ST_KC;
      end
      ST_KC: begin
        bkt_ra  = key_c;
        key_d   = key_c;
        state_d = ST_KD;
      end
      ST_KD: begin
        bkt_we = 1'b1;
        bkt_wa = key_q;
        bkt_wd = bkt_rd + NW'(1);
        if (place_q) begin
          sa_we = 1'b1;
          sa_wa = bkt_rd[AW-1:0];
          sa_wd = first_q ? i_q[AW-1:0] : p_q;
        end
        i_d = i_end ? '0 : i_nx;
        if (!i_end) begin
          state_d = ST_KA;
        end else if (!place_q) begin
          run_d   = '0;
          state_d = ST_PFX_A;
        end else if (first_q) begin
          c_d     = '0;
          state_d = ST_CL_A;
        end else begin
          state_d = ST_NC_A;
        end
      end
      ST_PFX_A: begin
        bkt_ra  = i_q[BW-1:0];
        state_d = ST_PFX_B;
      end
      ST_PFX_B: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[BW-1:0];
        bkt_wd = run_q;
        run_d  = run_q + bkt_rd;
        i_d    = i_end ? '0 : i_nx;
        if (i_end) begin
          place_d = 1'b1;
          state_d = ST_KA;
        end else begin
          state_d = ST_PFX_A;
        end
      end
      ST_CL_A: begin
        sa_ra   = i_q[AW-1:0];
        state_d = ST_CL_B;
      end
      ST_CL_B: begin
        a_d     = sa_rd;
        txt_ra  = sa_rd;
        state_d = ST_CL_C;
      end
      ST_CL_C: begin
        cls_we = 1'b1;
        cls_wa = a_q;
        cls_wd = cnew;
        c_d    = cnew;
        prev_d = txt_rd;
        i_d    = i_end ? '0 : i_nx;
        if (i_end) begin
          first_d = 1'b0;
          half_d  = HW'(1);
          state_d = (HW'(1) < HW'(n_q)) ? ST_SH_A : ST_RK_A;
        end else begin
          state_d = ST_CL_A;
        end
      end
      ST_SH_A: begin
        sa_ra   = i_q[AW-1:0];
        state_d = ST_SH_B;
      end
      ST_SH_B: begin
        sh_we = 1'b1;
        sh_wa = i_q[AW-1:0];
        sh_wd = mod_add(sa_rd, n_q - half_q[NW-1:0], n_q);
        i_d   = i_end ? '0 : i_nx;
        if (i_end) begin
          place_d = 1'b0;
          state_d = ST_CLR;
        end else begin
          state_d = ST_SH_A;
        end
      end
      ST_NC_A: begin
        sa_ra   = '0;
        c_d     = '0;
        state_d = ST_NC_S;
      end
      ST_NC_S: begin
        a_d     = sa_rd;
        state_d = ST_NC_W;
      end
      ST_NC_W: begin
        ncls_we = 1'b1;
        ncls_wa = a_q;
        ncls_wd = c_q;
        if (i_end) begin
          i_d     = '0;
          state_d = ST_CP_A;
        end else begin
          sa_ra   = i_nx[AW-1:0];
          state_d = ST_NC_B;
        end
      end
      ST_NC_B: begin
        b_d     = sa_rd;
        cls_ra  = a_q;
        state_d = ST_NC_C;
      end
      ST_NC_C: begin
        x_d     = cls_rd;
        cls_ra  = b_q;
        state_d = ST_NC_D;
      end
      ST_NC_D: begin
        d_d     = (x_q != cls_rd);
        cls_ra  = mod_add(a_q, half_q[NW-1:0], n_q);
        state_d = ST_NC_E;
      end
      ST_NC_E: begin
        x_d     = cls_rd;
        cls_ra  = mod_add(b_q, half_q[NW-1:0], n_q);
        state_d = ST_NC_F;
      end
      ST_NC_F: begin
        if (d_q || (x_q != cls_rd)) begin
          c_d = c_q + AW'(1);
        end
        a_d     = b_q;
        i_d     = i_nx;
        state_d = ST_NC_W;
      end
      ST_CP_A: begin
        ncls_ra = i_q[AW-1:0];
        state_d = ST_CP_B;
      end
      ST_CP_B: begin
        cls_we = 1'b1;
        cls_wa = i_q[AW-1:0];
        cls_wd = ncls_rd;
        i_d    = i_end ? '0 : i_nx;
        if (i_end) begin
          half_d  = half2;
          state_d = (half2 < HW'(n_q)) ? ST_SH_A : ST_RK_A;
        end else begin
          state_d = ST_CP_A;
        end
      end
      ST_RK_A: begin
        sa_ra   = i_q[AW-1:0];
        state_d = ST_RK_B;
      end
      ST_RK_B: begin
        ncls_we = 1'b1;
        ncls_wa = sa_rd;
        ncls_wd = i_q[AW-1:0];
        i_d     = i_end ? '0 : i_nx;
        if (i_end) begin
          h_d     = '0;
          total_d = '0;
          state_d = ST_KS_A;
        end else begin
          state_d = ST_RK_A;
        end
      end
      ST_KS_A: begin
        if (h_q != '0) begin
          h_d = h_q - NW'(1);
        end
        ncls_ra = i_q[AW-1:0];
        state_d = ST_KS_B;
      end
      ST_KS_B: begin
        if (ncls_rd != '0) begin
          sa_ra   = ncls_rd - AW'(1);
          state_d = ST_KS_C;
        end else begin
          h_d     = '0;
          i_d     = i_nx;
          state_d = i_end ? ST_RES_A : ST_KS_A;
        end
      end
      ST_KS_C: begin
        k_d     = sa_rd;
        state_d = ST_KS_D;
      end
      ST_KS_D: begin
        if ((ih < (NW+1)'(n_q)) && (kh < (NW+1)'(n_q))) begin
          txt_ra  = ih[AW-1:0];
          state_d = ST_KS_E;
        end else begin
          total_d = total_q + TW'(h_q);
          i_d     = i_nx;
          state_d = i_end ? ST_RES_A : ST_KS_A;
        end
      end
      ST_KS_E: begin
        tx_d    = txt_rd;
        txt_ra  = kh[AW-1:0];
        state_d = ST_KS_F;
      end
      ST_KS_F: begin
        if (tx_q == txt_rd) begin
          h_d     = h_q + NW'(1);
          state_d = ST_KS_D;
        end else begin
          total_d = total_q + TW'(h_q);
          i_d     = i_nx;
          state_d = i_end ? ST_RES_A : ST_KS_A;
        end
      end
      ST_RES_A: begin
        prod_d  = TW'(n_q) * TW'(n_q - NW'(1));
        state_d = ST_RES_B;
      end
      ST_RES_B: begin
        // hold until the previous word has left the output register
        if (!(ov_q && out_stall_i)) begin
          cnt_d   = COUNT_W'((prod_q >> 1) - total_q);
          obad_d  = bad_q;
          olong_d = long_q;
          ov_d    = 1'b1;
          len_d   = '0;
          bad_d   = 1'b0;
          long_d  = 1'b0;
          i_d     = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      len_q   <= '0;
      bad_q   <= 1'b0;
      long_q  <= 1'b0;
      first_q <= 1'b0;
      place_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      len_q   <= len_d;
      bad_q   <= bad_d;
      long_q  <= long_d;
      first_q <= first_d;
      place_q <= place_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    half_q  <= half_d;
    c_q     <= c_d;
    p_q     <= p_d;
    a_q     <= a_d;
    b_q     <= b_d;
    x_q     <= x_d;
    k_q     <= k_d;
    key_q   <= key_d;
    run_q   <= run_d;
    h_q     <= h_d;
    prev_q  <= prev_d;
    tx_q    <= tx_d;
    d_q     <= d_d;
    total_q <= total_d;
    prod_q  <= prod_d;
    cnt_q   <= cnt_d;
    obad_q  <= obad_d;
    olong_q <= olong_d;
  end

endmodule

// ----- src/dsc_ram.sv -----
module dsc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
